FILE: rtl/pqme_pkg.sv
// ----------------------------------------------------------------------------
// pqme_pkg
// Shared types and codes of the process queue with longest-wait eviction.
// ----------------------------------------------------------------------------
package pqme_pkg;

   localparam logic [1:0] KIND_ENQUEUE = 2'd0;
   localparam logic [1:0] KIND_EXECUTE = 2'd1;
   localparam logic [1:0] KIND_EVICT   = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [15:0] wait_time;
      logic [7:0]  pri;
      logic [15:0] id;
   } entry_type;

   typedef struct packed {
      logic [1:0] status;
      entry_type  entry;
   } result_type;

endpackage

FILE: rtl/pqme_ram.sv
// ----------------------------------------------------------------------------
// pqme_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pqme_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  pqme_pkg::entry_type wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output pqme_pkg::entry_type rd_data
);

   pqme_pkg::entry_type mem [DEPTH];
   pqme_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pqme_ctrl.sv
// ----------------------------------------------------------------------------
// pqme_ctrl
// Command sequencer: ring pointers, head read, eviction scan and gap close.
// ----------------------------------------------------------------------------
module pqme_ctrl #(
   parameter int QUEUE_DEPTH = 16,
   parameter int IDX_W       = 4,
   parameter int CNT_W       = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_kind,
   input  pqme_pkg::entry_type  req_entry,
   output logic                 res_valid,
   input  logic                 res_ready,
   output pqme_pkg::result_type res,
   output logic                 wr_en,
   output logic [IDX_W-1:0]     wr_addr,
   output pqme_pkg::entry_type  wr_data,
   output logic [IDX_W-1:0]     rd_addr,
   input  pqme_pkg::entry_type  rd_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } state_type;

   state_type            state_ff;
   logic [IDX_W-1:0]     head_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     idx_ff;
   logic                 pend_ff;
   logic [CNT_W-1:0]     pend_idx_ff;
   logic [CNT_W-1:0]     best_idx_ff;
   pqme_pkg::entry_type  best_ff;
   pqme_pkg::result_type res_ff;

   logic accept;
   logic issue;

   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign issue     = (idx_ff < count_ff);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot_of(head_ff, count_ff);
      wr_data = req_entry;
      rd_addr = head_ff;
      case (state_ff)
         ST_IDLE: begin
            wr_en = accept && (req_kind == pqme_pkg::KIND_ENQUEUE)
                    && (count_ff < CNT_W'(QUEUE_DEPTH));
         end
         ST_SCAN: begin
            rd_addr = slot_of(head_ff, idx_ff);
         end
         ST_SHIFT: begin
            rd_addr = slot_of(head_ff, idx_ff);
            wr_en   = pend_ff;
            wr_addr = slot_of(head_ff, pend_idx_ff);
            wr_data = rd_data;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  idx_ff  <= '0;
                  pend_ff <= 1'b0;
                  case (req_kind)
                     pqme_pkg::KIND_ENQUEUE: begin
                        state_ff <= ST_DONE;
                        if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
                           count_ff <= count_ff + CNT_W'(1);
                           res_ff   <= '{status: pqme_pkg::STATUS_OK, entry: '0};
                        end else begin
                           res_ff   <= '{status: pqme_pkg::STATUS_FULL, entry: '0};
                        end
                     end
                     pqme_pkg::KIND_EXECUTE: begin
                        if (count_ff == '0) begin
                           res_ff   <= '{status: pqme_pkg::STATUS_EMPTY, entry: '0};
                           state_ff <= ST_DONE;
                        end else begin
                           res_ff   <= '{status: pqme_pkg::STATUS_OK, entry: '0};
                           state_ff <= ST_EXEC;
                        end
                     end
                     pqme_pkg::KIND_EVICT: begin
                        if (count_ff == '0) begin
                           res_ff   <= '{status: pqme_pkg::STATUS_EMPTY, entry: '0};
                           state_ff <= ST_DONE;
                        end else begin
                           res_ff   <= '{status: pqme_pkg::STATUS_OK, entry: '0};
                           state_ff <= ST_SCAN;
                        end
                     end
                     default: begin
                        res_ff   <= '{status: pqme_pkg::STATUS_OK, entry: '0};
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_EXEC: begin
               res_ff.entry <= rd_data;
               head_ff      <= slot_of(head_ff, CNT_W'(1));
               count_ff     <= count_ff - CNT_W'(1);
               state_ff     <= ST_DONE;
            end
            ST_SCAN: begin
               pend_ff     <= issue;
               pend_idx_ff <= idx_ff;
               if (issue) begin
                  idx_ff <= idx_ff + CNT_W'(1);
               end
               if (pend_ff) begin
                  if ((pend_idx_ff == '0) || (rd_data.wait_time > best_ff.wait_time)) begin
                     best_ff     <= rd_data;
                     best_idx_ff <= pend_idx_ff;
                  end
               end
               if (!issue && !pend_ff) begin
                  idx_ff   <= best_idx_ff + CNT_W'(1);
                  state_ff <= ST_SHIFT;
               end
            end
            ST_SHIFT: begin
               pend_ff     <= issue;
               pend_idx_ff <= idx_ff - CNT_W'(1);
               if (issue) begin
                  idx_ff <= idx_ff + CNT_W'(1);
               end
               if (!issue && !pend_ff) begin
                  count_ff     <= count_ff - CNT_W'(1);
                  res_ff.entry <= best_ff;
                  state_ff     <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (res_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: rtl/process_queue_max_wait_evict_top.sv
// From accept to rsp_tvalid: enqueue goes straight to the done state, execute first
// reads the head entry, and evict scans the stored entries, then closes the gap;
// rsp_tvalid is registered from the done state. One command at a time, taken only
// when idle; the eviction scan and gap close share the single entry store read port.
// Synchronous active-high reset empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
// process_queue_max_wait_evict_top
// Ordered process queue with head execute and longest-wait eviction.
// ----------------------------------------------------------------------------
module process_queue_max_wait_evict_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // proc_id[15:0], priority_in[23:16], wait_in[39:24]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_id[15:0], out_priority[23:16], out_wait[39:24]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   pqme_pkg::entry_type  req_entry;
   pqme_pkg::result_type res;
   logic                 res_valid;
   logic                 res_ready;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   pqme_pkg::entry_type  wr_data;
   logic [IDX_W-1:0]     rd_addr;
   pqme_pkg::entry_type  rd_data;

   logic                 rsp_tvalid_ff;
   pqme_pkg::result_type rsp_word_ff;

   assign req_entry = pqme_pkg::entry_type'(req_tdata);

   pqme_ram #(
      .DEPTH  (QUEUE_DEPTH),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pqme_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_tuser),
      .req_entry (req_entry),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   assign res_ready = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_tvalid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_word_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = 40'(rsp_word_ff.entry);
   assign rsp_tuser  = rsp_word_ff.status;

endmodule
